>>> src/a2l_pkg.sv
// Package for the start-code to length-prefixed unit converter.
// Holds the address width, the command struct between the front and back ends,
// the register and result-kind codes, and the header length clamp. No dependencies.
`default_nettype none
package a2l_pkg;

  localparam int AddrBits    = 32;
  localparam int FifoDepth   = 4;
  localparam int FifoPtrBits = $clog2(FifoDepth);
  localparam int FifoCntBits = $clog2(FifoDepth + 1);

  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = 4;

  localparam logic [CfgIdxBits-1:0] CFG_LENGTH_BYTES    = 1'd0;
  localparam logic [CfgIdxBits-1:0] CFG_STRIP_EMULATION = 1'd1;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_DESC    = 2'd2;

  localparam logic [7:0] SC_LAST   = 8'h01;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [7:0] EPB_BYTE  = 8'h03;

  typedef logic [AddrBits-1:0] addr_t;

  typedef struct packed {
    logic [3:0] length_bytes;
    logic       strip_emulation;
  } cfg_t;

  // One input's worth of work: zero writes, an optional byte write, an optional close.
  typedef struct packed {
    addr_t       pay_addr;
    logic [2:0]  zeros;
    logic        byte_vld;
    logic [7:0]  data;
    logic        close;
    addr_t       hdr_addr;
    logic [3:0]  hdr_len;
    logic [31:0] size;
  } cmd_t;

  function automatic logic [3:0] clamp_len(input logic [3:0] l);
    logic [3:0] r;
    r = l;
    if (l == 4'd0) r = 4'd1;
    if (l > 4'd8) r = 4'd8;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/a2l_front.sv
// Front end: scans stream bytes for start codes, tracks held zeros, addresses
// and sizes, and pushes one command per byte that causes any write.
// Depends on a2l_pkg.
`default_nettype none
module a2l_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  a2l_pkg::cfg_t    cfg_i,
  input  wire              in_vld_i,
  input  wire  [7:0]       in_byte_i,
  input  wire              in_end_i,
  output logic             push_o,
  output a2l_pkg::cmd_t    cmd_o
);
  import a2l_pkg::*;

  logic [1:0]  la_cnt_q, la_cnt_d;
  logic [1:0]  zero_run_q, zero_run_d;
  logic        inside_q, inside_d;
  addr_t       hdr_addr_q, hdr_addr_d;
  addr_t       next_addr_q, next_addr_d;
  logic [31:0] pay_cnt_q, pay_cnt_d;
  logic [3:0]  unit_len_q, unit_len_d;

  logic       is_sc, is_zero, is_other;
  logic [1:0] la_after;
  logic [2:0] base_z, z;
  logic [1:0] zr_z;
  logic       strip_hit, bv, close, open;
  logic [3:0] len_eff;
  logic [2:0] adv;

  always_comb begin
    is_sc    = (in_byte_i == SC_LAST) && (la_cnt_q >= 2'd2);
    is_zero  = !is_sc && (in_byte_i == ZERO_BYTE);
    is_other = !is_sc && !is_zero;
    len_eff  = clamp_len(cfg_i.length_bytes);

    la_after = 2'd0;
    base_z   = 3'd0;
    if (is_zero) begin
      if (la_cnt_q == 2'd3) begin
        la_after = 2'd3;
        base_z   = 3'd1;
      end else begin
        la_after = la_cnt_q + 2'd1;
      end
    end else if (is_other) begin
      base_z = {1'b0, la_cnt_q};
    end

    z = 3'd0;
    if (inside_q) begin
      z = base_z + (in_end_i ? {1'b0, la_after} : 3'd0);
    end

    if (z == 3'd0) begin
      zr_z = zero_run_q;
    end else if (z == 3'd1) begin
      zr_z = (zero_run_q == 2'd0) ? 2'd1 : 2'd2;
    end else begin
      zr_z = 2'd2;
    end

    strip_hit = cfg_i.strip_emulation && (zr_z == 2'd2) && (in_byte_i == EPB_BYTE);
    bv        = inside_q && is_other && !strip_hit;
    close     = inside_q && (is_sc || in_end_i);
    open      = is_sc && !in_end_i;
    adv       = z + {2'b00, bv};

    la_cnt_d    = la_after;
    zero_run_d  = (is_other && inside_q) ? 2'd0 : zr_z;
    inside_d    = inside_q;
    hdr_addr_d  = hdr_addr_q;
    next_addr_d = next_addr_q + addr_t'(adv);
    pay_cnt_d   = pay_cnt_q + 32'(adv);
    unit_len_d  = unit_len_q;

    if (is_sc) begin
      inside_d = 1'b0;
    end
    if (open) begin
      unit_len_d  = len_eff;
      hdr_addr_d  = next_addr_q;
      next_addr_d = next_addr_q + addr_t'(len_eff);
      pay_cnt_d   = 32'd0;
      zero_run_d  = 2'd0;
      inside_d    = 1'b1;
    end
    if (in_end_i) begin
      la_cnt_d    = 2'd0;
      zero_run_d  = 2'd0;
      inside_d    = 1'b0;
      hdr_addr_d  = '0;
      next_addr_d = '0;
      pay_cnt_d   = 32'd0;
    end

    cmd_o.pay_addr = next_addr_q;
    cmd_o.zeros    = z;
    cmd_o.byte_vld = bv;
    cmd_o.data     = in_byte_i;
    cmd_o.close    = close;
    cmd_o.hdr_addr = hdr_addr_q;
    cmd_o.hdr_len  = unit_len_q;
    cmd_o.size     = pay_cnt_q + 32'(adv);

    push_o = in_vld_i && ((z != 3'd0) || bv || close);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_cnt_q    <= 2'd0;
      zero_run_q  <= 2'd0;
      inside_q    <= 1'b0;
      hdr_addr_q  <= '0;
      next_addr_q <= '0;
      pay_cnt_q   <= 32'd0;
      unit_len_q  <= 4'd4;
    end else if (in_vld_i) begin
      la_cnt_q    <= la_cnt_d;
      zero_run_q  <= zero_run_d;
      inside_q    <= inside_d;
      hdr_addr_q  <= hdr_addr_d;
      next_addr_q <= next_addr_d;
      pay_cnt_q   <= pay_cnt_d;
      unit_len_q  <= unit_len_d;
    end
  end

endmodule
`default_nettype wire

>>> src/a2l_fifo.sv
// Command queue between the front and back ends, a few entries of flops.
// Depends on a2l_pkg.
`default_nettype none
module a2l_fifo (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  a2l_pkg::cmd_t    cmd_i,
  input  wire              pop_i,
  output a2l_pkg::cmd_t    cmd_o,
  output logic             full_o,
  output logic             empty_o
);
  import a2l_pkg::*;

  cmd_t                   mem_q [FifoDepth];
  logic [FifoPtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntBits-1:0] cnt_q;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == FifoCntBits'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + FifoPtrBits'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + FifoPtrBits'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + FifoCntBits'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - FifoCntBits'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> src/a2l_back.sv
// Back end: expands each queued command into payload, header and descriptor
// beats, one per cycle unless stalled, to an output register. Uses a2l_pkg.
`default_nettype none
module a2l_back (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  a2l_pkg::cmd_t    cmd_i,
  input  wire              cmd_vld_i,
  output logic             pop_o,
  output logic             out_vld_o,
  input  wire              out_rdy_i,
  output logic [1:0]       kind_o,
  output logic [31:0]      write_addr_o,
  output logic [7:0]       write_byte_o,
  output logic [31:0]      unit_location_o,
  output logic [31:0]      unit_size_o,
  output logic             last_o
);
  import a2l_pkg::*;

  logic [3:0]  idx_q, idx_d;
  logic        vld_q;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] addr_q, addr_d;
  logic [7:0]  byte_q, byte_d;
  logic [31:0] loc_q, loc_d;
  logic [31:0] size_q, size_d;
  logic        last_q, last_d;

  logic [3:0] zc, pe, total, j;
  logic [2:0] k;
  logic       load;

  always_comb begin
    zc    = {1'b0, cmd_i.zeros};
    pe    = zc + {3'b000, cmd_i.byte_vld};
    total = pe + (cmd_i.close ? cmd_i.hdr_len + 4'd1 : 4'd0);
    j     = idx_q - pe;
    k     = 3'(cmd_i.hdr_len - 4'd1 - j);
    load  = cmd_vld_i && (!vld_q || out_rdy_i);

    kind_d = KIND_PAYLOAD;
    addr_d = 32'd0;
    byte_d = 8'd0;
    loc_d  = 32'd0;
    size_d = 32'd0;
    if (idx_q < zc) begin
      addr_d = 32'(cmd_i.pay_addr + addr_t'(idx_q));
    end else if (idx_q < pe) begin
      addr_d = 32'(cmd_i.pay_addr + addr_t'(zc));
      byte_d = cmd_i.data;
    end else if (j < cmd_i.hdr_len) begin
      kind_d = KIND_HEADER;
      addr_d = 32'(cmd_i.hdr_addr + addr_t'(j));
      case (k)
        3'd0:    byte_d = cmd_i.size[7:0];
        3'd1:    byte_d = cmd_i.size[15:8];
        3'd2:    byte_d = cmd_i.size[23:16];
        3'd3:    byte_d = cmd_i.size[31:24];
        default: byte_d = 8'd0;
      endcase
    end else begin
      kind_d = KIND_DESC;
      loc_d  = 32'(cmd_i.hdr_addr + addr_t'(cmd_i.hdr_len));
      size_d = cmd_i.size;
    end
    last_d = (idx_q == total - 4'd1);
    pop_o  = load && last_d;
    idx_d  = pop_o ? 4'd0 : idx_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 4'd0;
      vld_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= idx_d;
        vld_q <= 1'b1;
      end else if (out_rdy_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      addr_q <= addr_d;
      byte_q <= byte_d;
      loc_q  <= loc_d;
      size_q <= size_d;
      last_q <= last_d;
    end
  end

  assign out_vld_o       = vld_q;
  assign kind_o          = kind_q;
  assign write_addr_o    = addr_q;
  assign write_byte_o    = byte_q;
  assign unit_location_o = loc_q;
  assign unit_size_o     = size_q;
  assign last_o          = last_q;

endmodule
`default_nettype wire

>>> src/annexb_to_length_prefixed_nal.sv
// Top level of the start-code to length-prefixed unit converter.
// Instantiates a2l_front, a2l_fifo and a2l_back; depends on a2l_pkg.
//
// Takes one stream byte per beat and accepts a new byte every cycle while the
// four-entry command queue has room. Each byte that causes writes becomes one
// queued command; the back end sends one result beat per cycle unless stalled.
// A byte yields one result for a plain payload byte, up to four when held zeros
// are released, and clamp_len(length_bytes)+1 more when a unit closes (at most 13).
// The result sequencer in the back end sets the sustained rate; the queue absorbs
// the burst at each unit close. No clearing pass follows reset.
`default_nettype none
module annexb_to_length_prefixed_nal (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [a2l_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  wire  [a2l_pkg::CfgDataBits-1:0] cfg_data_i,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire  [7:0]                     s_axis_tdata,  // in_byte
  input  wire                            s_axis_tlast,  // stream_end
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // write_addr[31:0], write_byte[39:32], unit_location[71:40], unit_size[103:72]
  output logic [103:0]                   m_axis_tdata,
  output logic [1:0]                     m_axis_tuser,  // kind
  output logic                           m_axis_tlast   // last_of_run
);
  import a2l_pkg::*;

  cfg_t        cfg_q;
  logic        acc;
  logic        push, pop, full, empty;
  cmd_t        cmd_in, cmd_out;
  logic [1:0]  kind;
  logic [31:0] waddr, loc, size;
  logic [7:0]  wbyte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.length_bytes    <= 4'd4;
      cfg_q.strip_emulation <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LENGTH_BYTES:    cfg_q.length_bytes    <= cfg_data_i[3:0];
        CFG_STRIP_EMULATION: cfg_q.strip_emulation <= cfg_data_i[0];
        default:             cfg_q <= cfg_q;
      endcase
    end
  end

  assign s_axis_tready = !full;
  assign acc           = s_axis_tvalid && !full;

  a2l_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_vld_i  (acc),
    .in_byte_i (s_axis_tdata),
    .in_end_i  (s_axis_tlast),
    .push_o    (push),
    .cmd_o     (cmd_in)
  );

  a2l_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .full_o  (full),
    .empty_o (empty)
  );

  a2l_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd_out),
    .cmd_vld_i       (!empty),
    .pop_o           (pop),
    .out_vld_o       (m_axis_tvalid),
    .out_rdy_i       (m_axis_tready),
    .kind_o          (kind),
    .write_addr_o    (waddr),
    .write_byte_o    (wbyte),
    .unit_location_o (loc),
    .unit_size_o     (size),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {size, loc, wbyte, waddr};
  assign m_axis_tuser = kind;

endmodule
`default_nettype wire
